### design/bfss_pkg.sv
// Package with constants and types shared by the bfloat16 scalar scale block.
package bfss_pkg;
  localparam logic [31:0] UnitScale = 32'h3F80_0000;
  localparam logic [31:0] CanonNan  = 32'h7FC0_0000;
  localparam logic [15:0] RoundBias = 16'h7FFF;

  typedef struct packed {
    logic        sign;
    logic        is_nan;
    logic        is_inf;
    logic        is_zero;
    logic        unit;
    logic        last;
    logic [15:0] word;
  } bfss_ctl_t;
endpackage

### design/bf16_scalar_scale.sv
// Top level: bfloat16 word times single-precision scale, five-stage pipeline.
//
// Usage: an item (value_in_i, last_in_i) is taken at each rising edge where
// start is high and busy is low. busy is always low, so one beat can enter in
// every cycle. Each result appears on value_out_o/last_out_o for exactly one
// cycle, marked by done_o. It passes through five register stages: operand
// unpack, 8x24 significand multiply, normalization and leading-zero count,
// subnormal shift and round to single, and the narrowing to bfloat16.
// Throughput is one beat per cycle.
//
// The scale register is written through cfg_valid_i/cfg_ready_o/cfg_data_i;
// cfg_ready_o is always high. Write it only while no beat is in flight.
// Reset clears all stage valid bits and sets the scale to 1.0, under which
// words pass through bit for bit. The receiver cannot stall, so no result is
// ever held back; nothing upstream waits on the output side.
// A NaN product becomes the canonical quiet NaN, and the final narrowing adds
// 0x7FFF plus the product's bit 16, so results are rounded twice by design.
module bf16_scalar_scale
  import bfss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] value_in_i,
  input  logic        last_in_i,
  output logic        done_o,
  output logic [15:0] value_out_o,
  output logic        last_out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] scale_q;
  logic [4:0]  vld_q;
  logic        in_fire;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign in_fire     = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= UnitScale;
      vld_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        scale_q <= cfg_data_i;
      end
      vld_q <= {vld_q[3:0], in_fire};
    end
  end

  // Stage 1: unpack both operands. The exponents are summed as one signed
  // unbiased value, with subnormals normalized to an explicit leading one later.
  bfss_ctl_t   c1_q;
  logic [7:0]  ma1_q;
  logic [23:0] mb1_q;
  logic signed [10:0] e1_q;

  logic [7:0]  ea, eb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  bfss_ctl_t   c1_d;

  always_comb begin
    ea     = value_in_i[14:7];
    eb     = scale_q[30:23];
    a_nan  = (ea == 8'hFF) && (value_in_i[6:0] != '0);
    b_nan  = (eb == 8'hFF) && (scale_q[22:0] != '0);
    a_inf  = (ea == 8'hFF) && (value_in_i[6:0] == '0);
    b_inf  = (eb == 8'hFF) && (scale_q[22:0] == '0);
    a_zero = (value_in_i[14:0] == '0);
    b_zero = (scale_q[30:0] == '0);
    c1_d.sign    = value_in_i[15] ^ scale_q[31];
    c1_d.is_nan  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
    c1_d.is_inf  = a_inf || b_inf;
    c1_d.is_zero = a_zero || b_zero;
    c1_d.unit    = (scale_q == UnitScale);
    c1_d.last    = last_in_i;
    c1_d.word    = value_in_i;
  end

  always_ff @(posedge clk_i) begin
    c1_q  <= c1_d;
    ma1_q <= {(ea != '0), value_in_i[6:0]};
    mb1_q <= {(eb != '0), scale_q[22:0]};
    // Subnormal exponent is 1 - bias.
    e1_q  <= 11'(signed'({3'b0, (ea == '0) ? 8'd1 : ea}))
           + 11'(signed'({3'b0, (eb == '0) ? 8'd1 : eb})) - 11'sd254;
  end

  // Stage 2: significand product, 32 bits, value = p * 2^(e - 30).
  bfss_ctl_t   c2_q;
  logic [31:0] p2_q;
  logic signed [10:0] e2_q;

  always_ff @(posedge clk_i) begin
    c2_q <= c1_q;
    p2_q <= 32'(ma1_q) * 32'(mb1_q);
    e2_q <= e1_q;
  end

  // Stage 3: normalize so bit 31 is the leading one.
  bfss_ctl_t   c3_q;
  logic [31:0] p3_q;
  logic signed [10:0] e3_q;
  logic [4:0]  lz;

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (p2_q[i]) lz = 5'(31 - i);
    end
  end

  always_ff @(posedge clk_i) begin
    c3_q <= c2_q;
    p3_q <= p2_q << lz;
    // Value = 1.f * 2^(e3), where bit 31 weighs 2^(e2 - 30 + 31 - lz).
    e3_q <= e2_q + 11'sd1 - 11'(signed'({6'b0, lz}));
  end

  // Stage 4: shift for subnormal results, round to nearest even, pack single.
  bfss_ctl_t   c4_q;
  logic [31:0] r4_q;

  logic signed [10:0] be;
  logic [5:0]  sh;
  logic [32:0] ext;
  logic [31:0] sig;
  logic        sticky, rnd;
  logic [24:0] m;
  logic [31:0] pack;

  always_comb begin
    be  = e3_q + 11'sd127;
    sh  = 6'd0;
    if (be < 11'sd1) begin
      sh = ((11'sd1 - be) > 11'sd33) ? 6'd33 : 6'(11'sd1 - be);
      be = 11'sd0;
    end
    ext    = {p3_q, 1'b0} >> sh;
    sig    = ext[32:1];
    sticky = (ext[0]) || (sig[6:0] != '0) || ((sh != '0) &&
             (({p3_q, 1'b0} & ~({33{1'b1}} << sh)) != '0));
    rnd    = sig[7] && (sticky || sig[8]);
    m      = {1'b0, sig[31:8]} + 25'(rnd);
    if (m[24]) begin
      m  = m >> 1;
      be = be + 11'sd1;
    end else if (be == 11'sd0 && m[23]) begin
      be = 11'sd1;
    end
    if (c3_q.is_nan) begin
      pack = CanonNan;
    end else if (c3_q.is_inf || be >= 11'sd255) begin
      pack = {c3_q.sign, 8'hFF, 23'd0};
    end else if (c3_q.is_zero) begin
      pack = {c3_q.sign, 31'd0};
    end else begin
      pack = {c3_q.sign, be[7:0], m[22:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    c4_q <= c3_q;
    r4_q <= pack;
  end

  // Stage 5: narrow to bfloat16 with the add-bias-plus-lsb rule, or pass the word through at unit scale.
  logic [31:0] nar;
  logic [15:0] out_q;
  logic        last_q;

  assign nar = r4_q + {16'd0, RoundBias} + {31'd0, r4_q[16]};

  always_ff @(posedge clk_i) begin
    out_q  <= c4_q.unit ? c4_q.word : nar[31:16];
    last_q <= c4_q.last;
  end

  assign done_o      = vld_q[4];
  assign value_out_o = out_q;
  assign last_out_o  = last_q;

  a_lat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> ##5 done_o) else $error("result lost");
  a_nodone : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(in_fire, 5) |-> !done_o) else $error("spurious result");
  a_unit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[3] && c4_q.unit) |=> (value_out_o == $past(c4_q.word)))
    else $error("unit scale not passed through");

endmodule

### verif/tb_bf16_scalar_scale.sv
// Testbench for bf16_scalar_scale: scored random and directed streams over many scale settings.
`timescale 1ns / 100ps

module tb_bf16_scalar_scale
  import bfss_pkg::*;
;

  // One scaled word as it should leave the block.
  typedef struct {
    logic [15:0] word;
    logic        last;
  } scaled_beat_t;

  // The scoreboard holds its own copy of the scale register and works out the
  // scaled word for every beat the block accepts. Results leave in order, so
  // a plain queue of expected beats is enough.
  class scale_scoreboard;
    logic [31:0]  scale;
    scaled_beat_t pending[$];
    int           mismatches;
    int           checked;

    function new();
      scale      = UnitScale;
      mismatches = 0;
      checked    = 0;
    endfunction

    // Single-precision product of the widened word and the scale, rounded once
    // to nearest even with subnormals kept, then narrowed to bfloat16 by the
    // add-0x7FFF-plus-lsb rule. Integer arithmetic only, so no host rounding
    // mode can leak in.
    function logic [15:0] scaled_word(logic [15:0] w);
      logic [31:0]     a;
      logic [31:0]     p;
      logic            sgn;
      logic            a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
      int              ea, eb, e0, n, q, k;
      longint unsigned prod, r, rem, half;
      longint          bits;
      if (scale == UnitScale) return w;
      a      = {w, 16'h0000};
      sgn    = a[31] ^ scale[31];
      ea     = a[30:23];
      eb     = scale[30:23];
      a_nan  = (ea == 255) && (a[22:0] != 0);
      b_nan  = (eb == 255) && (scale[22:0] != 0);
      a_inf  = (ea == 255) && (a[22:0] == 0);
      b_inf  = (eb == 255) && (scale[22:0] == 0);
      a_zero = (a[30:0] == 0);
      b_zero = (scale[30:0] == 0);
      if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
        p = CanonNan;
      end else if (a_inf || b_inf) begin
        p = {sgn, 8'hFF, 23'h0};
      end else if (a_zero || b_zero) begin
        p = {sgn, 31'h0};
      end else begin
        prod = longint'({ea != 0, a[22:0]}) * longint'({eb != 0, scale[22:0]});
        // Value is prod * 2^e0, with subnormal operands taking exponent one.
        e0 = ((ea != 0) ? ea : 1) + ((eb != 0) ? eb : 1) - 300;
        n  = 0;
        for (int i = 0; i < 48; i++) if (prod[i]) n = i;
        // Quantum of the result: 24 significant bits, never finer than the
        // smallest subnormal.
        q = n + e0 - 23;
        if (q < -149) q = -149;
        k = q - e0;
        if (k <= 0) begin
          r = prod << (-k);
        end else if (k > 50) begin
          r = 0;
        end else begin
          r    = prod >> k;
          rem  = prod & ((64'd1 << k) - 1);
          half = 64'd1 << (k - 1);
          if (rem > half || (rem == half && r[0])) r++;
        end
        // Exponent and fraction add up as integers, which also covers the
        // carry out of rounding and the step from subnormal to normal.
        bits = longint'(q + 150) * 64'h80_0000 + longint'(r) - 64'h80_0000;
        if (bits >= 64'h7F80_0000) bits = 64'h7F80_0000;
        p = {sgn, bits[30:0]};
      end
      p = p + {16'h0000, RoundBias} + {31'h0, p[16]};
      return p[31:16];
    endfunction

    function void note_input(logic [15:0] w, logic l);
      scaled_beat_t b;
      b.word = scaled_word(w);
      b.last = l;
      pending.push_back(b);
    endfunction

    function void check_result(logic [15:0] w, logic l);
      scaled_beat_t b;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word=%h last=%b", w, l);
        return;
      end
      b = pending.pop_front();
      if (w !== b.word || l !== b.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch scale=%h: expected word=%h last=%b, got word=%h last=%b",
                   scale, b.word, b.last, w, l);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [15:0] value_in_i;
  logic        last_in_i;
  logic        done_o;
  logic [15:0] value_out_o;
  logic        last_out_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i;

  scale_scoreboard sb;
  int              scales_used;

  bf16_scalar_scale dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .value_in_i (value_in_i),
    .last_in_i  (last_in_i),
    .done_o     (done_o),
    .value_out_o(value_out_o),
    .last_out_o (last_out_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Outputs are read at the rising edge, before the block's own updates land,
  // so each strobed result is scored in the cycle it was presented.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(value_out_o, last_out_o);
  end

  // Presents one beat and holds it until the block takes it. The next call
  // (or an idle call) updates start once in the following step.
  task automatic send_beat(logic [15:0] w, logic l);
    start      <= 1'b1;
    value_in_i <= w;
    last_in_i  <= l;
    do @(posedge clk_i); while (busy);
    sb.note_input(w, l);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Waits until every result in flight has come out of the five-stage
  // pipeline, then idles on for margin.
  task automatic drain();
    idle_cycles(1);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // The scale may only change with the pipeline empty.
  task automatic write_scale(logic [31:0] s);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= s;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.scale = s;
    scales_used++;
  endtask

  // Edge words: zeros, infinities, quiet and signaling NaNs, the largest
  // finite values, subnormals, and a few ordinary numbers.
  task automatic send_edge_words();
    logic [15:0] words[15];
    words = '{16'h0000, 16'h8000, 16'h7F80, 16'hFF80, 16'h7FC0, 16'h7F81, 16'hFFFF,
              16'h7F7F, 16'hFF7F, 16'h0001, 16'h8001, 16'h0080, 16'h3F80, 16'hBF80,
              16'h4049};
    foreach (words[i]) send_beat(words[i], i[0]);
  endtask

  // Bursts of random length, mostly separated by random gaps; some bursts are
  // long enough to fill the pipeline.
  task automatic random_stream(int count);
    int          burst;
    logic [15:0] w;
    while (count > 0) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && count > 0; i++) begin
        w = 16'($urandom());
        // Bias some words toward finite normals with a mid-range exponent.
        if ($urandom_range(0, 3) == 0) w[14:7] = 8'($urandom_range(100, 150));
        send_beat(w, $urandom_range(0, 7) == 0);
        count--;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
    end
  endtask

  function automatic logic [31:0] random_scale();
    logic [31:0] s;
    s = $urandom();
    case ($urandom_range(0, 3))
      0: s[30:23] = 8'($urandom_range(110, 140));  // typical scale magnitudes
      1: s[30:23] = 8'($urandom_range(0, 3));      // tiny and subnormal scales
      2: s[30:23] = 8'($urandom_range(240, 254));  // huge scales, overflow likely
      default: ;
    endcase
    return s;
  endfunction

  initial begin
    logic [31:0] directed_scales[10];
    sb          = new();
    scales_used = 0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    value_in_i  = '0;
    last_in_i   = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The reset scale is 1.0: every word, NaN payloads included, passes through.
    send_edge_words();

    // Directed scales: just off unity, zero, the smallest subnormal, the
    // largest finite value, both infinities, a NaN, a plain power of two,
    // the smallest normal, and all ones.
    directed_scales = '{32'h3F80_0001, 32'h0000_0000, 32'h8000_0001, 32'h7F7F_FFFF,
                        32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001, 32'h4000_0000,
                        32'h0080_0000, 32'hFFFF_FFFF};
    foreach (directed_scales[i]) begin
      write_scale(directed_scales[i]);
      send_edge_words();
    end

    // Random phases, with a return to unity scale along the way.
    for (int ph = 0; ph < 10; ph++) begin
      write_scale((ph == 4) ? UnitScale : random_scale());
      random_stream(30);
      // Hold off until the pipeline has emptied, then carry on at this scale.
      drain();
      random_stream(28);
    end

    drain();
    $display("Covered %0d scale settings with %0d results scored.", scales_used, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Mismatches: %0d, results never seen: %0d", sb.mismatches, sb.pending.size());
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout waiting for results");
    $display("Test completed with failures");
    $finish;
  end

endmodule
